// File: rtl/alsse_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// alsse_pkg
// Shared types and constants for the packed key table engine.
// ----------------------------------------------------------------------------
package alsse_pkg;

	localparam int TABLE_DEPTH = 32;
	localparam int AW          = $clog2(TABLE_DEPTH);
	localparam int CW          = $clog2(TABLE_DEPTH + 1);
	localparam int KEY_W       = 30;

	typedef enum logic [2:0] {
		OP_INSERT   = 3'd0,
		OP_APPEND   = 3'd1,
		OP_LSEARCH  = 3'd2,
		OP_BSEARCH  = 3'd3,
		OP_DEL_SLOT = 3'd4,
		OP_DEL_KEY  = 3'd5,
		OP_SORT     = 3'd6,
		OP_NOP      = 3'd7
	} opcode_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_BAD_INDEX = 2'd2,
		ST_RSVD      = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_WR,
		S_LIN_RD,
		S_LIN_EV,
		S_DEL_RD,
		S_DEL_WR,
		S_BIN_RD,
		S_BIN_EV,
		S_SRT_RD0,
		S_SRT_LD,
		S_SRT_RD,
		S_SRT_EV,
		S_FIN
	} state_t;

	typedef struct packed {
		logic [2:0]       opcode;
		logic [KEY_W-1:0] key;
		logic [4:0]       slot;
	} cmd_t;

	typedef struct packed {
		logic [1:0] status;
		logic [4:0] found_index;
		logic [5:0] entry_count;
		logic       is_sorted;
	} rsp_t;

	typedef struct packed {
		logic eq;
		logic gt;
	} cmp_t;

endpackage
`default_nettype wire

// File: rtl/alsse_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// alsse_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module alsse_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// File: rtl/alsse_cmp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// alsse_cmp
// Shared key comparator: equality and unsigned greater-than.
// ----------------------------------------------------------------------------
module alsse_cmp (
	input  wire logic [alsse_pkg::KEY_W-1:0] a,
	input  wire logic [alsse_pkg::KEY_W-1:0] b,
	output alsse_pkg::cmp_t                  res
);

	always_comb begin
		res.eq = (a == b);
		res.gt = (a > b);
	end

endmodule
`default_nettype wire

// File: rtl/array_list_search_sort_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// array_list_search_sort_engine
// Packed key table with insert, append, search, delete and sort commands.
// ----------------------------------------------------------------------------
// One command is taken at a time; cmd_stall stays high until its response is
// loaded. Every step goes through the single table RAM (one read, one
// write a cycle, registered read) and one shared comparator. Insert and delete
// shift each entry behind the slot by one place, linear search reads one
// entry per step, binary search halves the span per probe, and sort runs
// count-1 bubble passes over the valid entries. Reset needs no clearing pass:
// the entry count marks the valid prefix.
module array_list_search_sort_engine (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cmd_valid,
	output logic                 cmd_stall,
	input  wire alsse_pkg::cmd_t cmd,
	output logic                 rsp_valid,
	input  wire logic            rsp_stall,
	output alsse_pkg::rsp_t      rsp
);

	localparam int AW = alsse_pkg::AW;
	localparam int CW = alsse_pkg::CW;
	localparam int KW = alsse_pkg::KEY_W;

	alsse_pkg::state_t state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d, ptr_q, ptr_d, pos_q, pos_d;
	logic [CW-1:0] lo_q, lo_d, hi_q, hi_d, pass_q, pass_d;
	logic [KW-1:0] key_q, key_d, carry_q, carry_d;
	logic [2:0]    op_q, op_d;
	logic [1:0]    st_q, st_d;
	logic [AW-1:0] fnd_q, fnd_d;
	logic          sorted_q, sorted_d;
	logic          rsp_valid_q, rsp_valid_d;
	alsse_pkg::rsp_t rsp_q, rsp_d;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [KW-1:0] wdata, rdata, cmp_a, cmp_b;
	alsse_pkg::cmp_t cmp_r;
	logic [CW:0]   mid_sum;
	logic [CW-1:0] mid, at_c;
	logic          accept;

	alsse_ram #(.WIDTH(KW), .DEPTH(alsse_pkg::TABLE_DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	alsse_cmp u_cmp (
		.a   (cmp_a),
		.b   (cmp_b),
		.res (cmp_r)
	);

	assign accept    = cmd_valid && !cmd_stall;
	assign cmd_stall = (state_q != alsse_pkg::S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q} - (CW+1)'(1);
	assign mid       = CW'(mid_sum >> 1);
	assign at_c      = (cmd.opcode == alsse_pkg::OP_APPEND) ? cnt_q : CW'(cmd.slot);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= alsse_pkg::S_IDLE;
			cnt_q       <= '0;
			sorted_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			sorted_q    <= sorted_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		ptr_q   <= ptr_d;
		pos_q   <= pos_d;
		lo_q    <= lo_d;
		hi_q    <= hi_d;
		pass_q  <= pass_d;
		key_q   <= key_d;
		carry_q <= carry_d;
		op_q    <= op_d;
		st_q    <= st_d;
		fnd_q   <= fnd_d;
		rsp_q   <= rsp_d;
	end

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		ptr_d       = ptr_q;
		pos_d       = pos_q;
		lo_d        = lo_q;
		hi_d        = hi_q;
		pass_d      = pass_q;
		key_d       = key_q;
		carry_d     = carry_q;
		op_d        = op_q;
		st_d        = st_q;
		fnd_d       = fnd_q;
		sorted_d    = sorted_q;
		rsp_d       = rsp_q;
		rsp_valid_d = rsp_valid_q && rsp_stall;
		we          = 1'b0;
		waddr       = AW'(ptr_q);
		wdata       = rdata;
		raddr       = AW'(ptr_q);
		cmp_a       = rdata;
		cmp_b       = key_q;

		case (state_q)
			alsse_pkg::S_IDLE: begin
				if (accept) begin
					op_d  = cmd.opcode;
					key_d = cmd.key;
					st_d  = alsse_pkg::ST_DONE;
					fnd_d = '0;
					ptr_d = '0;
					lo_d  = '0;
					hi_d  = cnt_q;
					case (cmd.opcode)
						alsse_pkg::OP_INSERT, alsse_pkg::OP_APPEND: begin
							pos_d = at_c;
							ptr_d = (cnt_q == CW'(alsse_pkg::TABLE_DEPTH)) ?
								CW'(alsse_pkg::TABLE_DEPTH - 1) : cnt_q;
							if (cmd.key == '0 || at_c > cnt_q ||
								at_c >= CW'(alsse_pkg::TABLE_DEPTH)) begin
								st_d    = alsse_pkg::ST_BAD_INDEX;
								state_d = alsse_pkg::S_FIN;
							end else begin
								state_d = alsse_pkg::S_INS_RD;
							end
						end
						alsse_pkg::OP_LSEARCH, alsse_pkg::OP_DEL_KEY: begin
							state_d = alsse_pkg::S_LIN_RD;
						end
						alsse_pkg::OP_BSEARCH: begin
							state_d = alsse_pkg::S_BIN_RD;
						end
						alsse_pkg::OP_DEL_SLOT: begin
							ptr_d = CW'(cmd.slot);
							if (CW'(cmd.slot) < cnt_q) begin
								fnd_d   = AW'(cmd.slot);
								state_d = alsse_pkg::S_DEL_RD;
							end else begin
								st_d    = alsse_pkg::ST_BAD_INDEX;
								state_d = alsse_pkg::S_FIN;
							end
						end
						alsse_pkg::OP_SORT: begin
							pass_d = cnt_q - CW'(1);
							if (cnt_q < CW'(2)) begin
								sorted_d = 1'b1;
								state_d  = alsse_pkg::S_FIN;
							end else begin
								state_d = alsse_pkg::S_SRT_RD0;
							end
						end
						default: begin
							state_d = alsse_pkg::S_FIN;
						end
					endcase
				end
			end
			alsse_pkg::S_INS_RD: begin
				if (ptr_q == pos_q) begin
					we       = 1'b1;
					waddr    = AW'(pos_q);
					wdata    = key_q;
					sorted_d = 1'b0;
					if (cnt_q != CW'(alsse_pkg::TABLE_DEPTH)) begin
						cnt_d = cnt_q + CW'(1);
					end
					state_d = alsse_pkg::S_FIN;
				end else begin
					raddr   = AW'(ptr_q - CW'(1));
					state_d = alsse_pkg::S_INS_WR;
				end
			end
			alsse_pkg::S_INS_WR: begin
				we      = 1'b1;
				waddr   = AW'(ptr_q);
				wdata   = rdata;
				ptr_d   = ptr_q - CW'(1);
				state_d = alsse_pkg::S_INS_RD;
			end
			alsse_pkg::S_LIN_RD: begin
				if (ptr_q == cnt_q) begin
					st_d    = alsse_pkg::ST_NOT_FOUND;
					state_d = alsse_pkg::S_FIN;
				end else begin
					state_d = alsse_pkg::S_LIN_EV;
				end
			end
			alsse_pkg::S_LIN_EV: begin
				if (cmp_r.eq) begin
					fnd_d   = AW'(ptr_q);
					state_d = (op_q == alsse_pkg::OP_DEL_KEY) ?
						alsse_pkg::S_DEL_RD : alsse_pkg::S_FIN;
				end else begin
					ptr_d   = ptr_q + CW'(1);
					state_d = alsse_pkg::S_LIN_RD;
				end
			end
			alsse_pkg::S_DEL_RD: begin
				raddr = AW'(ptr_q + CW'(1));
				if (({1'b0, ptr_q} + (CW+1)'(1)) >= {1'b0, cnt_q}) begin
					cnt_d   = cnt_q - CW'(1);
					state_d = alsse_pkg::S_FIN;
				end else begin
					state_d = alsse_pkg::S_DEL_WR;
				end
			end
			alsse_pkg::S_DEL_WR: begin
				we      = 1'b1;
				waddr   = AW'(ptr_q);
				wdata   = rdata;
				ptr_d   = ptr_q + CW'(1);
				state_d = alsse_pkg::S_DEL_RD;
			end
			alsse_pkg::S_BIN_RD: begin
				raddr = AW'(mid);
				ptr_d = mid;
				if (lo_q >= hi_q) begin
					st_d    = alsse_pkg::ST_NOT_FOUND;
					state_d = alsse_pkg::S_FIN;
				end else begin
					state_d = alsse_pkg::S_BIN_EV;
				end
			end
			alsse_pkg::S_BIN_EV: begin
				if (cmp_r.eq) begin
					fnd_d   = AW'(ptr_q);
					state_d = alsse_pkg::S_FIN;
				end else begin
					if (cmp_r.gt) begin
						hi_d = ptr_q;
					end else begin
						lo_d = ptr_q + CW'(1);
					end
					state_d = alsse_pkg::S_BIN_RD;
				end
			end
			alsse_pkg::S_SRT_RD0: begin
				raddr   = '0;
				state_d = alsse_pkg::S_SRT_LD;
			end
			alsse_pkg::S_SRT_LD: begin
				carry_d = rdata;
				ptr_d   = CW'(1);
				state_d = alsse_pkg::S_SRT_RD;
			end
			alsse_pkg::S_SRT_RD: begin
				if (ptr_q == cnt_q) begin
					we    = 1'b1;
					waddr = AW'(cnt_q - CW'(1));
					wdata = carry_q;
					if (pass_q == CW'(1)) begin
						sorted_d = 1'b1;
						state_d  = alsse_pkg::S_FIN;
					end else begin
						pass_d  = pass_q - CW'(1);
						state_d = alsse_pkg::S_SRT_RD0;
					end
				end else begin
					state_d = alsse_pkg::S_SRT_EV;
				end
			end
			alsse_pkg::S_SRT_EV: begin
				cmp_a = carry_q;
				cmp_b = rdata;
				we    = 1'b1;
				waddr = AW'(ptr_q - CW'(1));
				if (cmp_r.gt) begin
					wdata = rdata;
				end else begin
					wdata   = carry_q;
					carry_d = rdata;
				end
				ptr_d   = ptr_q + CW'(1);
				state_d = alsse_pkg::S_SRT_RD;
			end
			alsse_pkg::S_FIN: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_d.status      = st_q;
					rsp_d.found_index = 5'(fnd_q);
					rsp_d.entry_count = 6'(cnt_q);
					rsp_d.is_sorted   = sorted_q;
					rsp_valid_d       = 1'b1;
					state_d           = alsse_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = alsse_pkg::S_IDLE;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(alsse_pkg::TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != alsse_pkg::S_IDLE)
		else $error("engine idle after accepting a transaction");

	a_sort_sets_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == alsse_pkg::S_FIN && op_q == alsse_pkg::OP_SORT) |-> sorted_q)
		else $error("sorted flag clear after sort");

	a_bin_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == alsse_pkg::S_BIN_EV |-> (ptr_q >= lo_q && ptr_q < hi_q))
		else $error("bisection probe outside span");
`endif

endmodule
`default_nettype wire
